// ===== src/draft_tree_best_first_builder_macros.svh =====
// assertion macros for the draft tree builder
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef DRAFT_TREE_BEST_FIRST_BUILDER_MACROS_SVH
`define DRAFT_TREE_BEST_FIRST_BUILDER_MACROS_SVH

// same-cycle implication
`define DTB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DTB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dtb_pkg.sv =====
// shared types, constants and helpers of the draft tree builder
// no dependencies
package dtb_pkg;

    localparam int MAX_DEPTH    = 16;
    localparam int MAX_RANKS    = 8;
    localparam int MAX_NODES    = 64;
    localparam int HEAP_ENTRIES = 128;
    localparam int TOKEN_BITS   = 18;

    localparam int ROW_BITS   = $clog2(MAX_DEPTH);
    localparam int RANK_BITS  = $clog2(MAX_RANKS);
    localparam int TIX_BITS   = ROW_BITS + RANK_BITS;
    localparam int TABLE_SIZE = MAX_DEPTH * MAX_RANKS;
    localparam int NODE_BITS  = $clog2(MAX_NODES);
    localparam int CNT_BITS   = NODE_BITS + 1;
    localparam int HEAP_BITS  = $clog2(HEAP_ENTRIES);
    localparam int HCNT_BITS  = HEAP_BITS + 1;
    localparam int SEQ_BITS   = 8;
    localparam int PROB_BITS  = 24;
    localparam int SUM_BITS   = 25;
    localparam int DEPTH_BITS = 5;
    localparam int KCNT_BITS  = 4;

    localparam int IN_DATA_BITS  = 72;
    localparam int OUT_DATA_BITS = 104;

    localparam logic [1:0] CFG_BUDGET = 2'd0;
    localparam logic [1:0] CFG_CHAIN  = 2'd1;
    localparam logic [1:0] CFG_DEPTH  = 2'd2;
    localparam logic [1:0] CFG_RANKS  = 2'd3;

    typedef enum logic [18:0] {
        S_IDLE   = 19'h00001,
        S_INIT   = 19'h00002,
        S_C_RD   = 19'h00004,
        S_C_ADD  = 19'h00008,
        S_C_PUSH = 19'h00010,
        S_C_NEXT = 19'h00020,
        S_LOOP   = 19'h00040,
        S_SCAN   = 19'h00080,
        S_REMOVE = 19'h00100,
        S_TOK    = 19'h00200,
        S_DUP    = 19'h00400,
        S_RDP    = 19'h00800,
        S_ADD    = 19'h01000,
        S_SIB    = 19'h02000,
        S_CHK    = 19'h04000,
        S_CHILD  = 19'h08000,
        S_O_RD   = 19'h10000,
        S_O_LOAD = 19'h20000,
        S_O_HOLD = 19'h40000
    } t_state;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] key;
        logic [SEQ_BITS-1:0]        seq;
        logic [NODE_BITS-1:0]       parent;
        logic [DEPTH_BITS-1:0]      depth;
        logic [RANK_BITS-1:0]       rank;
    } t_heap_ent;

    typedef struct packed {
        logic [TOKEN_BITS-1:0]      tok;
        logic [NODE_BITS-1:0]       parent;
        logic [DEPTH_BITS-1:0]      depth;
        logic signed [SUM_BITS-1:0] sum;
    } t_node_ent;

    typedef struct packed {
        logic [TOKEN_BITS-1:0]       tok;
        logic signed [PROB_BITS-1:0] prob;
    } t_tab_ent;

    function automatic logic [TIX_BITS-1:0] tindex(input logic [DEPTH_BITS-1:0] row,
                                                   input logic [KCNT_BITS-1:0] rank);
        return {row[ROW_BITS-1:0], rank[RANK_BITS-1:0]};
    endfunction

    function automatic logic signed [SUM_BITS-1:0] sat_add(
        input logic signed [SUM_BITS-1:0] a, input logic signed [PROB_BITS-1:0] b);
        logic signed [SUM_BITS:0] s;
        s = (SUM_BITS+1)'(a) + (SUM_BITS+1)'(b);
        if (s > (SUM_BITS+1)'((1 << (SUM_BITS-1)) - 1))
            return SUM_BITS'((1 << (SUM_BITS-1)) - 1);
        else if (s < -(SUM_BITS+1)'(1 << (SUM_BITS-1)))
            return SUM_BITS'(-(1 << (SUM_BITS-1)));
        return s[SUM_BITS-1:0];
    endfunction

    function automatic logic better(input t_heap_ent a, input t_heap_ent b);
        return (a.key > b.key) || ((a.key == b.key) && (a.seq < b.seq));
    endfunction

endpackage

// ===== src/dtb_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module dtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/draft_tree_best_first_builder.sv =====
// Draft token tree builder: loads one candidate table entry per input beat; the beat
// with tlast starts a build, after which the tree streams out one node per beat.
// The build is run by one sequencer over memories: each expansion step scans the
// candidate heap memory one entry per cycle, scans the node memory for a duplicate
// sibling, then inserts the node and makes up to two pushes. Each node then streams
// out through a read, a load and a hold state. Input beats and register writes are
// not taken during the build or the output.
// Depends on dtb_pkg, dtb_ram and the assertion macro header.
`include "draft_tree_best_first_builder_macros.svh"

module draft_tree_best_first_builder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // depth_row, rank_index, log_prob, cand_token, root
    input  logic [dtb_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // node_index, node_token, parent, node_depth, visible_row
    output logic [dtb_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    output logic                               m_axis_tlast,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [1:0]                         i_cfg_addr,
    input  logic [5:0]                         i_cfg_data
);
    import dtb_pkg::*;

    t_state r_state, n_state;
    logic [5:0] r_budget;
    logic       r_chain;
    logic [4:0] r_tdepth;
    logic [3:0] r_rpd;

    logic [TOKEN_BITS-1:0] r_root, n_root;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic [HCNT_BITS-1:0]  r_hcnt, n_hcnt;
    logic [SEQ_BITS-1:0]   r_seq, n_seq;
    logic [DEPTH_BITS-1:0] r_dep, n_dep;
    logic [NODE_BITS-1:0]  r_cur, n_cur;
    logic [NODE_BITS-1:0]  r_nidx, n_nidx;
    logic signed [SUM_BITS-1:0] r_psum, n_psum;
    logic signed [SUM_BITS-1:0] r_key, n_key;
    logic [TOKEN_BITS-1:0] r_tok, n_tok;
    logic [HCNT_BITS-1:0]  r_si, n_si;
    logic [HCNT_BITS-1:0]  r_ri, n_ri;
    logic                  r_rv, n_rv;
    t_heap_ent             r_best, n_best;
    logic [HEAP_BITS-1:0]  r_bidx, n_bidx;
    t_heap_ent             r_last, n_last;
    logic [CNT_BITS-1:0]   r_oi, n_oi;
    logic                  r_ovalid, n_ovalid;
    logic [OUT_DATA_BITS-1:0] r_odata, n_odata;
    logic                  r_olast, n_olast;

    logic [DEPTH_BITS-1:0] w_l;
    logic [KCNT_BITS-1:0]  w_k;
    logic [CNT_BITS-1:0]   w_total;
    logic [5:0]            w_cd;

    logic                  tab_we;
    logic [TIX_BITS-1:0]   tab_waddr, tab_raddr;
    t_tab_ent              tab_wdata, tab_q;
    logic                  nd_we;
    logic [NODE_BITS-1:0]  nd_waddr, nd_raddr;
    t_node_ent             nd_wdata, nd_q;
    logic                  v_we;
    logic [NODE_BITS-1:0]  v_waddr, v_raddr;
    logic [MAX_NODES-1:0]  v_wdata, v_q;
    logic                  h_we;
    logic [HEAP_BITS-1:0]  h_waddr, h_raddr;
    t_heap_ent             h_wdata, h_q;

    logic                  w_push;
    t_heap_ent             w_pent;
    logic                  w_in_acc;

    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    assign w_l = (r_tdepth > DEPTH_BITS'(MAX_DEPTH)) ? DEPTH_BITS'(MAX_DEPTH) : r_tdepth;
    assign w_k = (r_rpd == '0) ? KCNT_BITS'(1) :
                 ((r_rpd > KCNT_BITS'(MAX_RANKS)) ? KCNT_BITS'(MAX_RANKS) : r_rpd);
    assign w_total = ((r_budget > 6'(MAX_NODES - 1)) ? CNT_BITS'(MAX_NODES - 1)
                                                     : CNT_BITS'(r_budget)) + CNT_BITS'(1);
    assign w_cd = (6'(w_l) < 6'(w_total - CNT_BITS'(1))) ? 6'(w_l)
                                                         : 6'(w_total - CNT_BITS'(1));

    dtb_ram #(.WIDTH($bits(t_tab_ent)), .DEPTH(TABLE_SIZE)) u_table (
        .i_clk(i_clk), .i_we(tab_we), .i_waddr(tab_waddr), .i_wdata(tab_wdata),
        .i_raddr(tab_raddr), .o_rdata(tab_q)
    );
    dtb_ram #(.WIDTH($bits(t_node_ent)), .DEPTH(MAX_NODES)) u_nodes (
        .i_clk(i_clk), .i_we(nd_we), .i_waddr(nd_waddr), .i_wdata(nd_wdata),
        .i_raddr(nd_raddr), .o_rdata(nd_q)
    );
    dtb_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_vis (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(v_q)
    );
    dtb_ram #(.WIDTH($bits(t_heap_ent)), .DEPTH(HEAP_ENTRIES)) u_heap (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_raddr(h_raddr), .o_rdata(h_q)
    );

    always_comb begin
        n_state = r_state;  n_root = r_root;   n_cnt = r_cnt;   n_hcnt = r_hcnt;
        n_seq = r_seq;      n_dep = r_dep;     n_cur = r_cur;   n_nidx = r_nidx;
        n_psum = r_psum;    n_key = r_key;     n_tok = r_tok;   n_si = r_si;
        n_ri = r_ri;        n_rv = r_rv;       n_best = r_best; n_bidx = r_bidx;
        n_last = r_last;    n_oi = r_oi;       n_ovalid = r_ovalid;
        n_odata = r_odata;  n_olast = r_olast;

        tab_we = 1'b0;
        tab_waddr = tindex({1'b0, s_axis_tdata[3:0]}, {1'b0, s_axis_tdata[6:4]});
        tab_wdata.prob = s_axis_tdata[30:7];
        tab_wdata.tok  = s_axis_tdata[48:31];
        tab_raddr = '0;
        nd_we = 1'b0;  nd_waddr = r_cnt[NODE_BITS-1:0];  nd_wdata = '0;  nd_raddr = '0;
        v_we = 1'b0;   v_waddr = r_cnt[NODE_BITS-1:0];   v_wdata = '0;   v_raddr = '0;
        h_we = 1'b0;   h_waddr = r_hcnt[HEAP_BITS-1:0];  h_wdata = '0;   h_raddr = '0;
        w_push = 1'b0; w_pent = '0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    tab_we = 1'b1;
                    if (s_axis_tlast) begin
                        n_root = s_axis_tdata[66:49];
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                nd_we = 1'b1;
                nd_waddr = '0;
                nd_wdata.tok = r_root;
                v_we = 1'b1;
                v_waddr = '0;
                v_wdata = MAX_NODES'(1);
                n_cnt = CNT_BITS'(1);
                n_hcnt = '0;
                n_seq = '0;
                n_cur = '0;
                if (w_total == CNT_BITS'(1) || w_l == '0) begin
                    n_oi = '0;
                    n_state = S_O_RD;
                end else if (r_chain) begin
                    n_dep = DEPTH_BITS'(1);
                    n_state = S_C_RD;
                end else begin
                    n_key = '0;
                    n_dep = '0;
                    tab_raddr = tindex('0, '0);
                    n_state = S_CHILD;
                end
            end
            S_C_RD: begin
                tab_raddr = tindex(r_dep - DEPTH_BITS'(1), '0);
                nd_raddr = r_cur;
                v_raddr = r_cur;
                n_state = S_C_ADD;
            end
            S_C_ADD: begin
                nd_we = 1'b1;
                nd_wdata.tok = tab_q.tok;
                nd_wdata.parent = r_cur;
                nd_wdata.depth = r_dep;
                nd_wdata.sum = sat_add(nd_q.sum, tab_q.prob);
                v_we = 1'b1;
                v_wdata = v_q | (MAX_NODES'(1) << r_cnt[NODE_BITS-1:0]);
                n_psum = nd_q.sum;
                n_nidx = r_cnt[NODE_BITS-1:0];
                n_cnt = r_cnt + CNT_BITS'(1);
                if (w_k > KCNT_BITS'(1)) begin
                    tab_raddr = tindex(r_dep - DEPTH_BITS'(1), KCNT_BITS'(1));
                    n_state = S_C_PUSH;
                end else begin
                    n_state = S_C_NEXT;
                end
            end
            S_C_PUSH: begin
                w_push = 1'b1;
                w_pent.key = sat_add(r_psum, tab_q.prob);
                w_pent.parent = r_cur;
                w_pent.depth = r_dep;
                w_pent.rank = RANK_BITS'(1);
                n_state = S_C_NEXT;
            end
            S_C_NEXT: begin
                n_cur = r_nidx;
                if (6'(r_dep) == w_cd) begin
                    n_state = S_LOOP;
                end else begin
                    n_dep = r_dep + DEPTH_BITS'(1);
                    n_state = S_C_RD;
                end
            end
            S_LOOP: begin
                if (r_hcnt != '0 && r_cnt < w_total) begin
                    n_si = '0;
                    n_rv = 1'b0;
                    n_state = S_SCAN;
                end else begin
                    n_oi = '0;
                    n_state = S_O_RD;
                end
            end
            S_SCAN: begin
                h_raddr = r_si[HEAP_BITS-1:0];
                if (r_si < r_hcnt) begin
                    n_si = r_si + HCNT_BITS'(1);
                    n_ri = r_si;
                    n_rv = 1'b1;
                end else begin
                    n_rv = 1'b0;
                end
                if (r_rv) begin
                    if (r_ri == '0 || better(h_q, r_best)) begin
                        n_best = h_q;
                        n_bidx = r_ri[HEAP_BITS-1:0];
                    end
                    if (r_ri == r_hcnt - HCNT_BITS'(1)) begin
                        n_last = h_q;
                        n_state = S_REMOVE;
                    end
                end
            end
            S_REMOVE: begin
                h_we = 1'b1;
                h_waddr = r_bidx;
                h_wdata = r_last;
                n_hcnt = r_hcnt - HCNT_BITS'(1);
                tab_raddr = tindex(r_best.depth - DEPTH_BITS'(1), {1'b0, r_best.rank});
                n_state = S_TOK;
            end
            S_TOK: begin
                n_tok = tab_q.tok;
                n_si = HCNT_BITS'(1);
                n_rv = 1'b0;
                n_state = (r_cnt == CNT_BITS'(1)) ? S_RDP : S_DUP;
            end
            S_DUP: begin
                nd_raddr = r_si[NODE_BITS-1:0];
                if (r_si < HCNT_BITS'(r_cnt)) begin
                    n_si = r_si + HCNT_BITS'(1);
                    n_ri = r_si;
                    n_rv = 1'b1;
                end else begin
                    n_rv = 1'b0;
                end
                if (r_rv) begin
                    if (nd_q.parent == r_best.parent && nd_q.tok == r_tok) begin
                        n_state = S_LOOP;
                    end else if (r_ri == HCNT_BITS'(r_cnt) - HCNT_BITS'(1)) begin
                        n_state = S_RDP;
                    end
                end
            end
            S_RDP: begin
                nd_raddr = r_best.parent;
                v_raddr = r_best.parent;
                n_state = S_ADD;
            end
            S_ADD: begin
                nd_we = 1'b1;
                nd_wdata.tok = r_tok;
                nd_wdata.parent = r_best.parent;
                nd_wdata.depth = r_best.depth;
                nd_wdata.sum = r_best.key;
                v_we = 1'b1;
                v_wdata = v_q | (MAX_NODES'(1) << r_cnt[NODE_BITS-1:0]);
                n_psum = nd_q.sum;
                n_cur = r_cnt[NODE_BITS-1:0];
                n_cnt = r_cnt + CNT_BITS'(1);
                n_key = r_best.key;
                n_dep = r_best.depth;
                if (KCNT_BITS'(r_best.rank) + KCNT_BITS'(1) < w_k) begin
                    tab_raddr = tindex(r_best.depth - DEPTH_BITS'(1),
                                       KCNT_BITS'(r_best.rank) + KCNT_BITS'(1));
                    n_state = S_SIB;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_SIB: begin
                w_push = 1'b1;
                w_pent.key = sat_add(r_psum, tab_q.prob);
                w_pent.parent = r_best.parent;
                w_pent.depth = r_best.depth;
                w_pent.rank = r_best.rank + RANK_BITS'(1);
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_dep < w_l) begin
                    tab_raddr = tindex(r_dep, '0);
                    n_state = S_CHILD;
                end else begin
                    n_state = S_LOOP;
                end
            end
            S_CHILD: begin
                w_push = 1'b1;
                w_pent.key = sat_add(r_key, tab_q.prob);
                w_pent.parent = r_cur;
                w_pent.depth = r_dep + DEPTH_BITS'(1);
                w_pent.rank = '0;
                n_state = S_LOOP;
            end
            S_O_RD: begin
                nd_raddr = r_oi[NODE_BITS-1:0];
                v_raddr = r_oi[NODE_BITS-1:0];
                n_state = S_O_LOAD;
            end
            S_O_LOAD: begin
                n_odata = '0;
                n_odata[5:0] = 6'(r_oi);
                n_odata[23:6] = nd_q.tok;
                n_odata[30:24] = (r_oi == '0) ? 7'h7F : 7'(nd_q.parent);
                n_odata[35:31] = nd_q.depth;
                n_odata[99:36] = 64'(v_q);
                n_olast = (r_oi + CNT_BITS'(1) == r_cnt);
                n_ovalid = 1'b1;
                n_state = S_O_HOLD;
            end
            S_O_HOLD: begin
                if (m_axis_tready) begin
                    n_ovalid = 1'b0;
                    if (r_olast) begin
                        n_state = S_IDLE;
                    end else begin
                        n_oi = r_oi + CNT_BITS'(1);
                        n_state = S_O_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_push && r_hcnt < HCNT_BITS'(HEAP_ENTRIES)) begin
            h_we = 1'b1;
            h_waddr = r_hcnt[HEAP_BITS-1:0];
            h_wdata = w_pent;
            h_wdata.seq = r_seq;
            n_hcnt = r_hcnt + HCNT_BITS'(1);
            n_seq = r_seq + SEQ_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_budget <= 6'd15;
            r_chain <= 1'b0;
            r_tdepth <= 5'd8;
            r_rpd <= 4'd4;
            r_cnt <= '0;
            r_hcnt <= '0;
            r_seq <= '0;
            r_rv <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_hcnt <= n_hcnt;
            r_seq <= n_seq;
            r_rv <= n_rv;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_addr)
                    CFG_BUDGET: r_budget <= i_cfg_data;
                    CFG_CHAIN:  r_chain <= i_cfg_data[0];
                    CFG_DEPTH:  r_tdepth <= i_cfg_data[4:0];
                    CFG_RANKS:  r_rpd <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_root <= n_root;   r_dep <= n_dep;   r_cur <= n_cur;   r_nidx <= n_nidx;
        r_psum <= n_psum;   r_key <= n_key;   r_tok <= n_tok;   r_si <= n_si;
        r_ri <= n_ri;       r_best <= n_best; r_bidx <= n_bidx; r_last <= n_last;
        r_oi <= n_oi;       r_odata <= n_odata; r_olast <= n_olast;
    end

    `DTB_ASSERT_NOW(a_heap_bound, 1'b1, r_hcnt <= HCNT_BITS'(HEAP_ENTRIES), "heap overflow")
    `DTB_ASSERT_NOW(a_node_bound, 1'b1, r_cnt <= CNT_BITS'(MAX_NODES), "node count overflow")
    `DTB_ASSERT_NEXT(a_build_start, w_in_acc && s_axis_tlast, r_state == S_INIT, "no build start")
    `DTB_ASSERT_NOW(a_out_state, m_axis_tvalid, r_state == S_O_HOLD, "beat outside output")

endmodule
